@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL; bodies compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define DPVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define DPVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPVC_ASSERT(lbl, prop, msg)
`define DPVC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/dpvc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dpvc_pkg;

  localparam int MAX_EXTREMA = 64;
  localparam int RING_DEPTH  = 4;

  localparam int SAMPLE_W   = 16;
  localparam int HOLD_W     = 8;
  localparam int CNT_W      = 7;
  localparam int TOTAL_W    = 22;
  localparam int HOLD_CNT_W = 9;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int RING_SUM_W = SAMPLE_W + SLOT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [HOLD_W-1:0]     HOLD_RESET   = HOLD_W'(16);
  localparam logic [CNT_W-1:0]      TARGET_RESET =
    (MAX_EXTREMA > 127) ? CNT_W'(127) : CNT_W'(MAX_EXTREMA);
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [HOLD_CNT_W-1:0] HOLD_MAX     = {HOLD_CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_LIMIT     = 2'd0,
    CFG_EXTREMA_TARGET = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  a_offset_sum;
    logic [TOTAL_W-1:0]  a_peak_sum;
    logic [TOTAL_W-1:0]  a_valley_sum;
    logic [CNT_W-1:0]    a_extrema_count;
    logic                a_done;
    logic [TOTAL_W-1:0]  b_offset_sum;
    logic [TOTAL_W-1:0]  b_peak_sum;
    logic [TOTAL_W-1:0]  b_valley_sum;
    logic [CNT_W-1:0]    b_extrema_count;
    logic                b_done;
  } out_t;

  // Per-channel status after one tracking step.
  typedef struct packed {
    logic [TOTAL_W-1:0] offset_sum;
    logic [TOTAL_W-1:0] peak_sum;
    logic [TOTAL_W-1:0] valley_sum;
    logic [CNT_W-1:0]   extrema_count;
    logic               done;
  } chan_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/dpvc_ring_mean.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpvc_ring_mean import dpvc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  in_t                 item,
  output logic [SAMPLE_W-1:0] mean_a,
  output logic [SAMPLE_W-1:0] mean_b
);

  logic [SAMPLE_W-1:0]   ring_a_r [RING_DEPTH];
  logic [SAMPLE_W-1:0]   ring_b_r [RING_DEPTH];
  logic [SLOT_W-1:0]     slot_r;
  logic [SAMPLE_W-1:0]   mean_a_r, mean_b_r;
  logic [RING_SUM_W-1:0] sum_a, sum_b;

  // Sum the ring as it stands once the new sample sits in its slot.
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (slot_r == SLOT_W'(i)) begin
        sum_a = sum_a + RING_SUM_W'(item.sample_a);
        sum_b = sum_b + RING_SUM_W'(item.sample_b);
      end else begin
        sum_a = sum_a + RING_SUM_W'(ring_a_r[i]);
        sum_b = sum_b + RING_SUM_W'(ring_b_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_a_r[i] <= '0;
        ring_b_r[i] <= '0;
      end
    end else if (load) begin
      ring_a_r[slot_r] <= item.sample_a;
      ring_b_r[slot_r] <= item.sample_b;
      slot_r           <= slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_a_r <= sum_a[RING_SUM_W-1:SLOT_W];
      mean_b_r <= sum_b[RING_SUM_W-1:SLOT_W];
    end
  end

  assign mean_a = mean_a_r;
  assign mean_b = mean_b_r;

endmodule

`default_nettype wire

@@ rtl/core/dpvc_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dpvc_tracker import dpvc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] mean,
  input  logic [HOLD_W-1:0]   hold_limit,
  input  logic [CNT_W-1:0]    extrema_target,
  output chan_stat_t          stat_nxt
);

  logic [SAMPLE_W-1:0]   peak_r, peak_nxt;
  logic [SAMPLE_W-1:0]   valley_r, valley_nxt;
  logic                  seek_valley_r, seek_valley_nxt;
  logic [HOLD_CNT_W-1:0] peak_hold_r, peak_hold_nxt;
  logic [HOLD_CNT_W-1:0] valley_hold_r, valley_hold_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [TOTAL_W-1:0]    offset_r, offset_nxt;
  logic [TOTAL_W-1:0]    peak_sum_r, peak_sum_nxt;
  logic [TOTAL_W-1:0]    valley_sum_r, valley_sum_nxt;

  logic                  active;
  logic                  peak_run, peak_beat, peak_conf;
  logic                  seek_mid, valley_run, valley_beat, valley_conf;
  logic [SAMPLE_W-1:0]   valley_mid;
  logic [HOLD_CNT_W-1:0] peak_hold_inc, valley_hold_inc;
  logic [SAMPLE_W:0]     offset_add;

  function automatic logic [HOLD_CNT_W-1:0] hold_inc(input logic [HOLD_CNT_W-1:0] c);
    return (c == HOLD_MAX) ? HOLD_MAX : c + HOLD_CNT_W'(1);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [SAMPLE_W:0]  b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(b);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  always_comb begin
    active = count_r < extrema_target;

    // Peak search.
    peak_run      = active && !seek_valley_r;
    peak_beat     = mean > peak_r;
    peak_hold_inc = hold_inc(peak_hold_r);
    peak_conf     = peak_run && !peak_beat &&
                    (peak_hold_inc > HOLD_CNT_W'(hold_limit));

    // Valley search runs in the same step right after a confirmed peak.
    seek_mid        = seek_valley_r | peak_conf;
    valley_run      = active && seek_mid;
    valley_mid      = peak_conf ? peak_r : valley_r;
    valley_beat     = mean < valley_mid;
    valley_hold_inc = hold_inc(valley_hold_r);
    valley_conf     = valley_run && !valley_beat &&
                      (valley_hold_inc > HOLD_CNT_W'(hold_limit));

    if (valley_conf) begin
      peak_nxt = valley_mid;
    end else if (peak_run && peak_beat) begin
      peak_nxt = mean;
    end else begin
      peak_nxt = peak_r;
    end

    if (peak_run) begin
      peak_hold_nxt = (peak_beat || peak_conf) ? '0 : peak_hold_inc;
    end else begin
      peak_hold_nxt = peak_hold_r;
    end

    valley_nxt = (valley_run && valley_beat) ? mean : valley_mid;

    if (valley_run) begin
      valley_hold_nxt = (valley_beat || valley_conf) ? '0 : valley_hold_inc;
    end else begin
      valley_hold_nxt = valley_hold_r;
    end

    seek_valley_nxt = seek_mid & ~valley_conf;

    // Both confirmations add to the offset in one saturating add.
    offset_add = (peak_conf ? {1'b0, peak_r} : '0) +
                 (valley_conf ? {1'b0, valley_mid} : '0);
    offset_nxt     = sat_add(offset_r, offset_add);
    peak_sum_nxt   = peak_conf ? sat_add(peak_sum_r, {1'b0, peak_r}) : peak_sum_r;
    valley_sum_nxt = valley_conf ? sat_add(valley_sum_r, {1'b0, valley_mid})
                                 : valley_sum_r;
    count_nxt      = count_r + CNT_W'(peak_conf) + CNT_W'(valley_conf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r        <= '0;
      valley_r      <= '0;
      seek_valley_r <= 1'b0;
      peak_hold_r   <= '0;
      valley_hold_r <= '0;
      count_r       <= '0;
      offset_r      <= '0;
      peak_sum_r    <= '0;
      valley_sum_r  <= '0;
    end else if (en) begin
      peak_r        <= peak_nxt;
      valley_r      <= valley_nxt;
      seek_valley_r <= seek_valley_nxt;
      peak_hold_r   <= peak_hold_nxt;
      valley_hold_r <= valley_hold_nxt;
      count_r       <= count_nxt;
      offset_r      <= offset_nxt;
      peak_sum_r    <= peak_sum_nxt;
      valley_sum_r  <= valley_sum_nxt;
    end
  end

  assign stat_nxt.offset_sum    = offset_nxt;
  assign stat_nxt.peak_sum      = peak_sum_nxt;
  assign stat_nxt.valley_sum    = valley_sum_nxt;
  assign stat_nxt.extrema_count = count_nxt;
  assign stat_nxt.done          = count_nxt >= extrema_target;

  // Only the hold counter of the side being searched may be nonzero.
  `DPVC_ASSERT(a_idle_hold_clear, (seek_valley_r ? (peak_hold_r == '0) : (valley_hold_r == '0)), "hold counter of idle side is nonzero")
  // A channel that reached its target keeps its count.
  `DPVC_ASSERT(a_frozen_count, (en && !active) |=> (count_r == $past(count_r)), "frozen channel changed its count")

endmodule

`default_nettype wire

@@ rtl/core/dual_peak_valley_calibrator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port group  Direction  Handshake           Payload
// in_*        input      in_valid/in_stall   in_data   (in_t: sample_a, sample_b)
// out_*       output     out_valid/out_stall out_data  (out_t: sums, counts, done)
// cfg_*       input      cfg_we              cfg_index, cfg_wdata
//
// One beat per clock sustained while out_stall is low; a result passes the mean and output registers.
// The first stage sums each ring (adder tree); the second runs the peak/valley step.
// Reset is synchronous on rst_n: rings, trackers and valid flags clear, hold_limit=16.
// A stalled output holds its beat; input keeps flowing until both stages are full.

module dual_peak_valley_calibrator_unit import dpvc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r;
  logic [HOLD_W-1:0]   hold_limit_r;
  logic [CNT_W-1:0]    target_r;
  logic                out_adv, in_acc, track_en;
  logic [SAMPLE_W-1:0] mean_a, mean_b;
  chan_stat_t          stat_a, stat_b;

  always_comb begin
    out_adv       = !out_valid_r || !out_stall;
    in_stall      = s1_valid_r && !out_adv;
    in_acc        = in_valid && !in_stall;
    track_en      = s1_valid_r && out_adv;
    s1_valid_nxt  = in_acc || (s1_valid_r && !out_adv);
    out_valid_nxt = track_en || (out_valid_r && out_stall);
  end

  dpvc_ring_mean u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .item   (in_data),
    .mean_a (mean_a),
    .mean_b (mean_b)
  );

  dpvc_tracker u_track_a (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (track_en),
    .mean           (mean_a),
    .hold_limit     (hold_limit_r),
    .extrema_target (target_r),
    .stat_nxt       (stat_a)
  );

  dpvc_tracker u_track_b (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (track_en),
    .mean           (mean_b),
    .hold_limit     (hold_limit_r),
    .extrema_target (target_r),
    .stat_nxt       (stat_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_limit_r <= HOLD_RESET;
      target_r     <= TARGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_LIMIT:     hold_limit_r <= cfg_wdata[HOLD_W-1:0];
        CFG_EXTREMA_TARGET: target_r     <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (track_en) begin
      out_r.a_offset_sum    <= stat_a.offset_sum;
      out_r.a_peak_sum      <= stat_a.peak_sum;
      out_r.a_valley_sum    <= stat_a.valley_sum;
      out_r.a_extrema_count <= stat_a.extrema_count;
      out_r.a_done          <= stat_a.done;
      out_r.b_offset_sum    <= stat_b.offset_sum;
      out_r.b_peak_sum      <= stat_b.peak_sum;
      out_r.b_valley_sum    <= stat_b.valley_sum;
      out_r.b_extrema_count <= stat_b.extrema_count;
      out_r.b_done          <= stat_b.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A beat in the mean stage is never dropped while the output is blocked.
  `DPVC_ASSERT(a_s1_held, (s1_valid_r && !out_adv) |=> s1_valid_r, "mean stage beat lost")
  // Every tracking step lands in the output register.
  `DPVC_ASSERT(a_step_to_out, track_en |=> out_valid_r, "tracking step produced no output")
  // Both stages come out of reset empty.
  `DPVC_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> (!s1_valid_r && !out_valid_r), "pipeline not empty after reset")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import dpvc_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SHOWN_MISMATCH  = 10;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_IDX   = 2'd3;
  localparam logic [CFG_DATA_W-1:0] TARGET_ALL_ONES = 8'hFF;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {SRC_WAVE, SRC_SLOW_WAVE, SRC_NOISE, SRC_RAIL} src_mode_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
    in_t                      beat;
    bit                       typed;
    out_t                     want;
  } stim_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] hold;
    logic [CFG_DATA_W-1:0] target;
    int unsigned           items;
    src_mode_t             mode;
  } phase_t;

  typedef struct {
    logic [SAMPLE_W-1:0]   peak;
    logic [SAMPLE_W-1:0]   valley;
    bit                    seek_valley;
    logic [HOLD_CNT_W-1:0] peak_hold;
    logic [HOLD_CNT_W-1:0] valley_hold;
    logic [CNT_W-1:0]      count;
    logic [TOTAL_W-1:0]    offset;
    logic [TOTAL_W-1:0]    peak_sum;
    logic [TOTAL_W-1:0]    valley_sum;
  } tracker_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [SAMPLE_W-1:0] ring_q [2][RING_DEPTH];
  logic [SLOT_W-1:0]   slot_q;
  tracker_t            trk [2];
  logic [HOLD_W-1:0]   hold_limit_q;
  logic [CNT_W-1:0]    target_q;
  out_t                pending_totals [$];

  // waveform generator state per channel
  logic [SAMPLE_W-1:0] level_now [2];
  int unsigned         level_left [2];

  int unsigned mismatches;
  int unsigned cycles;
  bit          hold_off_req;

  dual_peak_valley_calibrator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [TOTAL_W-1:0] add_sat(logic [TOTAL_W-1:0] a,
                                                 logic [SAMPLE_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(b);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [HOLD_CNT_W-1:0] hold_bump(logic [HOLD_CNT_W-1:0] c);
    return (c == HOLD_MAX) ? c : c + HOLD_CNT_W'(1);
  endfunction

  // One seek step; the valley branch runs right after a peak flip.
  function automatic tracker_t track_mean(tracker_t t, logic [SAMPLE_W-1:0] m);
    if (t.count >= target_q) return t;
    if (!t.seek_valley) begin
      if (m > t.peak) begin
        t.peak      = m;
        t.peak_hold = '0;
      end else begin
        t.peak_hold = hold_bump(t.peak_hold);
        if (t.peak_hold > HOLD_CNT_W'(hold_limit_q)) begin
          t.offset      = add_sat(t.offset, t.peak);
          t.peak_sum    = add_sat(t.peak_sum, t.peak);
          t.valley      = t.peak;
          t.count       = t.count + CNT_W'(1);
          t.peak_hold   = '0;
          t.seek_valley = 1'b1;
        end
      end
    end
    if (t.seek_valley) begin
      if (m < t.valley) begin
        t.valley      = m;
        t.valley_hold = '0;
      end else begin
        t.valley_hold = hold_bump(t.valley_hold);
        if (t.valley_hold > HOLD_CNT_W'(hold_limit_q)) begin
          t.offset      = add_sat(t.offset, t.valley);
          t.valley_sum  = add_sat(t.valley_sum, t.valley);
          t.peak        = t.valley;
          t.count       = t.count + CNT_W'(1);
          t.valley_hold = '0;
          t.seek_valley = 1'b0;
        end
      end
    end
    return t;
  endfunction

  function automatic out_t calibrate_step(in_t beat);
    logic [RING_SUM_W-1:0] sum;
    out_t r;
    ring_q[0][slot_q] = beat.sample_a;
    ring_q[1][slot_q] = beat.sample_b;
    slot_q = slot_q + SLOT_W'(1);
    for (int ch = 0; ch < 2; ch++) begin
      sum = '0;
      for (int k = 0; k < RING_DEPTH; k++) sum = sum + RING_SUM_W'(ring_q[ch][k]);
      trk[ch] = track_mean(trk[ch], sum[RING_SUM_W-1:2]);
    end
    r.a_offset_sum    = trk[0].offset;
    r.a_peak_sum      = trk[0].peak_sum;
    r.a_valley_sum    = trk[0].valley_sum;
    r.a_extrema_count = trk[0].count;
    r.a_done          = (trk[0].count >= target_q);
    r.b_offset_sum    = trk[1].offset;
    r.b_peak_sum      = trk[1].peak_sum;
    r.b_valley_sum    = trk[1].valley_sum;
    r.b_extrema_count = trk[1].count;
    r.b_done          = (trk[1].count >= target_q);
    return r;
  endfunction

  function automatic out_t done_only(bit a_done, bit b_done);
    out_t r;
    r        = '0;
    r.a_done = a_done;
    r.b_done = b_done;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
    stim_row_t r;
    r.kind          = ROW_ITEM;
    r.idx           = '0;
    r.val           = '0;
    r.beat.sample_a = a;
    r.beat.sample_b = b;
    r.typed         = 1'b0;
    r.want          = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                          out_t want);
    stim_row_t r;
    r       = item_row(a, b);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r      = item_row('0, '0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Step waveform: hold a level for a while so the seekers can confirm.
  function automatic logic [SAMPLE_W-1:0] wave_sample(int ch, bit slow);
    logic [SAMPLE_W:0] s;
    if (level_left[ch] == 0) begin
      level_left[ch] = slow ? $urandom_range(262, 330) : $urandom_range(20, 60);
      case ($urandom_range(9))
        0:       level_now[ch] = '0;
        1:       level_now[ch] = '1;
        default: level_now[ch] = SAMPLE_W'($urandom);
      endcase
    end
    level_left[ch]--;
    s = {1'b0, level_now[ch]} + (SAMPLE_W + 1)'(slow ? 0 : $urandom_range(0, 31));
    return s[SAMPLE_W] ? '1 : s[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] channel_sample(int ch, src_mode_t mode,
                                                         int unsigned n);
    case (mode)
      SRC_NOISE:     return SAMPLE_W'($urandom);
      SRC_RAIL:      if (n < 80) return '1;
      SRC_SLOW_WAVE: if ($urandom_range(99) < 2) return SAMPLE_W'($urandom);
      default:       if ($urandom_range(99) < 12) return SAMPLE_W'($urandom);
    endcase
    return wave_sample(ch, mode == SRC_SLOW_WAVE);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCH)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_beat(out_t got);
    out_t want;
    if (pending_totals.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCH) $display("mismatch: result beat with nothing expected");
      return;
    end
    want = pending_totals.pop_front();
    check_field("a_offset_sum",    32'(want.a_offset_sum),    32'(got.a_offset_sum));
    check_field("a_peak_sum",      32'(want.a_peak_sum),      32'(got.a_peak_sum));
    check_field("a_valley_sum",    32'(want.a_valley_sum),    32'(got.a_valley_sum));
    check_field("a_extrema_count", 32'(want.a_extrema_count), 32'(got.a_extrema_count));
    check_field("a_done",          32'(want.a_done),          32'(got.a_done));
    check_field("b_offset_sum",    32'(want.b_offset_sum),    32'(got.b_offset_sum));
    check_field("b_peak_sum",      32'(want.b_peak_sum),      32'(got.b_peak_sum));
    check_field("b_valley_sum",    32'(want.b_valley_sum),    32'(got.b_valley_sum));
    check_field("b_extrema_count", 32'(want.b_extrema_count), 32'(got.b_extrema_count));
    check_field("b_done",          32'(want.b_done),          32'(got.b_done));
  endtask

  task automatic send_beat(in_t beat, bit typed, out_t want, int unsigned gap);
    out_t predicted;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    predicted = calibrate_step(beat);
    pending_totals.push_back(typed ? want : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected beat, then let the pipe go quiet.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_HOLD_LIMIT:     hold_limit_q = val;
      CFG_EXTREMA_TARGET: target_q     = val[CNT_W-1:0];
      default:            ;
    endcase
    @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_beat(out_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (calm_left > 0) begin
        out_stall <= 1'b0;
        calm_left--;
      end else begin
        if ($urandom_range(99) < 3) calm_left = $urandom_range(50, 150);
        else stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    phase_t      phases [$];
    in_t         beat;
    int unsigned burst_left;
    bit          tx_calm;

    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    hold_off_req = 1'b0;
    mismatches   = 0;
    burst_left   = 0;
    tx_calm      = 1'b0;

    hold_limit_q = HOLD_RESET;
    target_q     = TARGET_RESET;
    slot_q       = '0;
    for (int ch = 0; ch < 2; ch++) begin
      trk[ch]        = '{default: '0};
      level_now[ch]  = '0;
      level_left[ch] = 0;
      for (int k = 0; k < RING_DEPTH; k++) ring_q[ch][k] = '0;
    end

    rows.push_back(typed_row(16'h0000, 16'h0000, done_only(1'b0, 1'b0)));
    // target zero: both channels frozen and done from the start
    rows.push_back(cfg_row(CFG_EXTREMA_TARGET, 8'd0));
    rows.push_back(typed_row(16'hFFFF, 16'hFFFF, done_only(1'b1, 1'b1)));
    rows.push_back(typed_row(16'h0000, 16'hFFFF, done_only(1'b1, 1'b1)));
    rows.push_back(cfg_row(CFG_EXTREMA_TARGET, CFG_DATA_W'(MAX_EXTREMA)));
    // unmapped index must leave both registers alone
    rows.push_back(cfg_row(CFG_SPARE_IDX, 8'h00));
    rows.push_back(item_row(16'hFFFF, 16'h0000));
    // hold limit zero: confirm on the first sample that fails to beat
    rows.push_back(cfg_row(CFG_HOLD_LIMIT, 8'd0));
    rows.push_back(item_row(16'hFFFF, 16'h0000));
    rows.push_back(item_row(16'hFFFF, 16'h0000));
    rows.push_back(item_row(16'hFFFF, 16'h0000));
    rows.push_back(item_row(16'hFFFF, 16'hFFFF));
    rows.push_back(item_row(16'h0000, 16'hFFFF));
    rows.push_back(item_row(16'h0000, 16'hFFFF));
    rows.push_back(item_row(16'h0000, 16'hFFFF));
    rows.push_back(item_row(16'h0000, 16'h0000));
    rows.push_back(cfg_row(CFG_HOLD_LIMIT, 8'hFF));
    rows.push_back(item_row(16'h8000, 16'h7FFF));
    rows.push_back(item_row(16'h0001, 16'hFFFE));
    rows.push_back(item_row(16'hAAAA, 16'h5555));
    rows.push_back(item_row(16'h5555, 16'hAAAA));
    rows.push_back(cfg_row(CFG_HOLD_LIMIT, HOLD_RESET));
    rows.push_back(item_row(16'hFFFF, 16'hFFFF));
    rows.push_back(item_row(16'hFFFF, 16'hFFFF));
    rows.push_back(item_row(16'h0000, 16'h0000));

    phases.push_back('{HOLD_RESET, 8'd24, 320, SRC_WAVE});
    phases.push_back('{8'd7, 8'd1, 100, SRC_NOISE});
    phases.push_back('{8'hFF, 8'd40, 300, SRC_SLOW_WAVE});
    phases.push_back('{8'd2, CFG_DATA_W'(MAX_EXTREMA), 330, SRC_WAVE});
    // all-ones target masks to the largest count; rail samples drive the totals to saturate
    phases.push_back('{8'd0, TARGET_ALL_ONES, 380, SRC_RAIL});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_beat(rows[i].beat, rows[i].typed, rows[i].want, pick_gap());
      end
    end

    foreach (phases[p]) begin
      settle_block();
      write_reg(CFG_HOLD_LIMIT, phases[p].hold);
      write_reg(CFG_EXTREMA_TARGET, phases[p].target);
      for (int unsigned n = 0; n < phases[p].items; n++) begin
        if (p == 0 && n == 100) begin
          // receiver holds off while beats keep coming, so the pipe fills
          hold_off_req = 1'b1;
          burst_left   = 60;
        end
        if (p == 0 && n == 200) settle_block();
        if (n % 100 == 0 && $urandom_range(99) < 40) tx_calm = !tx_calm;
        beat.sample_a = channel_sample(0, phases[p].mode, n);
        beat.sample_b = channel_sample(1, phases[p].mode, n);
        send_beat(beat, 1'b0, '0, (burst_left > 0 || tx_calm) ? 0 : pick_gap());
        if (burst_left > 0) burst_left--;
      end
    end

    settle_block();
    if (mismatches == 0 && pending_totals.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
